// ===== src/positional_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// positional_list_engine_assert.svh
// Assertion macros used by the checker of the list engine.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Clocked assertion that is switched off while reset is held low.
`define PLE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PLE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ple_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int PLE_CAPACITY   = 16;
    localparam int PLE_DATA_WIDTH = 32;

    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_APPEND = 3'd1,
        OP_READ   = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_PUT,
        ST_FETCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] new_value;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic              ok;
        logic [LEN_W-1:0]  length;
        logic              empty_res;
    } t_rsp;

endpackage

// ===== src/ple_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ple_ram #(
    parameter int   WIDTH = ple_pkg::PLE_DATA_WIDTH,
    parameter int   DEPTH = ple_pkg::PLE_CAPACITY,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/positional_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY words with insert, append, read, remove and
// clear by one-based position. The words sit in a RAM and are moved one at a
// time by a small sequencer when a gap is opened or closed.
//
//   channel  direction  payload  handshake
//   request  in         t_req    i_req_valid / o_req_ready
//   response out        t_rsp    o_rsp_valid / i_rsp_ready
//
// Clear, a failed request and any unknown op go straight to ST_DONE. Insert
// shifts the words from position p on towards the tail, then writes the new
// word; remove shifts the words after p towards the head. Each moved word
// costs a RAM read and a RAM write on the single read and write port pair.
// Reset (synchronous, active low) empties the list; the RAM is not cleared.
// A response held by the sink stalls the sequencer only in its last state, ST_DONE.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY   = ple_pkg::PLE_CAPACITY,
    parameter int DATA_WIDTH = ple_pkg::PLE_DATA_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ple_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ple_pkg::t_rsp o_rsp
);

    import ple_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > LEN_W) ? CW : LEN_W) + 1;
    localparam int XW   = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_stop, n_stop;
    logic [OP_W-1:0]       r_op, n_op;
    logic                  r_ok, n_ok;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic                  r_rsp_valid, n_rsp_valid;
    t_rsp                  r_rsp, n_rsp;

    logic                  w_accept;
    logic                  w_is_ins;
    logic                  w_rsp_free;
    logic [CMPW-1:0]       w_pos;
    logic [CMPW-1:0]       w_cnt;
    logic [CMPW-1:0]       w_pos_m1;
    logic                  w_full;
    logic                  w_rd_ok;
    logic                  w_ins_ok;
    logic [CW-1:0]         w_step;
    logic [CW-1:0]         w_new_count;
    logic [CMPW-1:0]       w_new_count_ext;
    logic [XW-1:0]         w_new_ext;
    logic [XW-1:0]         w_rd_ext;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    ple_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ple_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_accept   = i_req_valid && o_req_ready;
    assign w_is_ins   = (r_op == OP_INSERT);
    assign w_rsp_free = !r_rsp_valid || i_rsp_ready;

    assign w_pos    = CMPW'(i_req.position);
    assign w_cnt    = CMPW'(r_count);
    assign w_pos_m1 = w_pos - CMPW'(1);
    assign w_full   = (w_cnt >= CMPW'(CAPACITY));
    assign w_rd_ok  = (w_pos != '0) && (w_pos <= w_cnt);
    assign w_ins_ok = !w_full && (w_pos != '0) && (w_pos <= w_cnt + CMPW'(1));

    // The one index adder: walks down towards the head on insert and up
    // towards the tail on remove.
    assign w_step = w_is_ins ? (r_idx - CW'(1)) : (r_idx + CW'(1));

    assign w_new_ext = XW'(i_req.new_value);
    assign w_rd_ext  = XW'(ram_rdata);

    always_comb begin
        unique case (r_op)
            OP_INSERT, OP_APPEND: w_new_count = r_ok ? (r_count + CW'(1)) : r_count;
            OP_REMOVE:            w_new_count = r_ok ? (r_count - CW'(1)) : r_count;
            OP_CLEAR:             w_new_count = '0;
            default:              w_new_count = r_count;
        endcase
    end

    assign w_new_count_ext = CMPW'(w_new_count);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.op)
                        OP_INSERT: begin
                            if (!w_ins_ok) begin
                                n_state = ST_DONE;
                            end else if (r_count != w_pos_m1[CW-1:0]) begin
                                n_state = ST_RD;
                            end else begin
                                n_state = ST_PUT;
                            end
                        end
                        OP_APPEND: n_state = w_full ? ST_DONE : ST_PUT;
                        OP_READ:   n_state = w_rd_ok ? ST_FETCH : ST_DONE;
                        OP_REMOVE: n_state = (w_rd_ok && (w_pos < w_cnt)) ? ST_RD : ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD: n_state = ST_WR;
            ST_WR: begin
                if (w_step == r_stop) begin
                    n_state = w_is_ins ? ST_PUT : ST_DONE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_PUT:   n_state = ST_DONE;
            ST_FETCH: n_state = ST_DONE;
            ST_DONE: begin
                if (w_rsp_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and RAM control
    always_comb begin
        o_req_ready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];
        ram_wdata   = r_word;
        ram_re      = 1'b0;
        ram_raddr   = r_idx[AW-1:0];
        unique case (r_state)
            ST_IDLE: o_req_ready = 1'b1;
            ST_RD: begin
                ram_re    = 1'b1;
                ram_raddr = w_step[AW-1:0];
            end
            ST_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_PUT:   ram_we = 1'b1;
            ST_FETCH: ram_re = 1'b1;
            ST_DONE:  o_req_ready = 1'b0;
            default:  o_req_ready = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_stop      = r_stop;
        n_op        = r_op;
        n_ok        = r_ok;
        n_word      = r_word;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;

        if (w_accept) begin
            n_op   = i_req.op;
            n_word = w_new_ext[DATA_WIDTH-1:0];
            n_idx  = w_pos_m1[CW-1:0];
            n_stop = w_pos_m1[CW-1:0];
            unique case (i_req.op)
                OP_INSERT: begin
                    n_ok  = w_ins_ok;
                    n_idx = r_count;
                end
                OP_APPEND: begin
                    n_ok   = !w_full;
                    n_idx  = r_count;
                    n_stop = r_count;
                end
                OP_READ: n_ok = w_rd_ok;
                OP_REMOVE: begin
                    n_ok   = w_rd_ok;
                    n_stop = r_count - CW'(1);
                end
                OP_CLEAR: n_ok = 1'b1;
                default:  n_ok = 1'b0;
            endcase
        end

        if (r_state == ST_WR) begin
            n_idx = w_step;
        end

        if ((r_state == ST_DONE) && w_rsp_free) begin
            n_count          = w_new_count;
            n_rsp_valid      = 1'b1;
            n_rsp.ok         = r_ok;
            n_rsp.length     = w_new_count_ext[LEN_W-1:0];
            n_rsp.empty_res  = (w_new_count == '0);
            n_rsp.read_value = ((r_op == OP_READ) && r_ok) ? w_rd_ext[WORD_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_stop <= n_stop;
        r_op   <= n_op;
        r_ok   <= n_ok;
        r_word <= n_word;
        r_rsp  <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== src/ple_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_chk
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

module ple_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_ready,
    input ple_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input logic          i_rsp_ready,
    input ple_pkg::t_rsp o_rsp
);

    import ple_pkg::*;

    // A response that is not taken must stay put.
    `PLE_ASSERT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp), "response changed while stalled")

    // A failed request returns no data word; only a successful read carries one.
    `PLE_ASSERT(a_fail_zero, i_clk, i_rst_n, o_rsp_valid && !o_rsp.ok |-> o_rsp.read_value == '0, "failed request returned data")

    // An empty list always reports a length of zero.
    `PLE_ASSERT(a_empty_len, i_clk, i_rst_n, o_rsp_valid && o_rsp.empty_res |-> o_rsp.length == '0, "empty list with non-zero length")

    // The engine works on one request at a time.
    `PLE_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && o_req_ready |=> !o_req_ready, "request taken while busy")

endmodule

bind positional_list_engine ple_chk u_ple_chk (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list engine. Requests are driven
// in random bursts, while the response side stalls on patterns of its own.
// A behavioural list kept in a queue predicts each response when its
// request transfer takes place. Every response is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import ple_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 40;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int OP_MAX_CODE  = (1 << OP_W) - 1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum {RX_STEADY, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    logic [WORD_W-1:0] list_words[$];
    t_rsp              expected_rsp[$];
    int                error_count  = 0;
    int                cycle_count  = 0;
    int                burst_left   = 0;
    int                hold_request = 0;

    positional_list_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one request to the behavioural list and returns its response.
    function automatic t_rsp apply_list_op(input t_req r);
        t_rsp res;
        int   n;
        int   p;
        n = list_words.size();
        p = r.position;
        res = '0;
        case (t_op'(r.op))
            OP_INSERT: begin
                if (n < PLE_CAPACITY && p >= 1 && p <= n + 1) begin
                    list_words.insert(p - 1, r.new_value);
                    res.ok = 1'b1;
                end
            end
            OP_APPEND: begin
                if (n < PLE_CAPACITY) begin
                    list_words.push_back(r.new_value);
                    res.ok = 1'b1;
                end
            end
            OP_READ: begin
                if (p >= 1 && p <= n) begin
                    res.read_value = list_words[p - 1];
                    res.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (p >= 1 && p <= n) begin
                    list_words.delete(p - 1);
                    res.ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                list_words.delete();
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.length    = LEN_W'(list_words.size());
        res.empty_res = (list_words.size() == 0);
        return res;
    endfunction

    // Responses are checked before the prediction of a new request is queued.
    always @(posedge clk) begin : response_check
        t_rsp want;
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch($sformatf("response with nothing expected: %h", rsp));
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  rsp.read_value, want.read_value));
                    if (rsp.ok !== want.ok)
                        report_mismatch($sformatf("ok %b, expected %b", rsp.ok, want.ok));
                    if (rsp.length !== want.length)
                        report_mismatch($sformatf("length %0d, expected %0d",
                                                  rsp.length, want.length));
                    if (rsp.empty_res !== want.empty_res)
                        report_mismatch($sformatf("empty_res %b, expected %b",
                                                  rsp.empty_res, want.empty_res));
                end
            end
            if (req_valid && req_ready)
                expected_rsp.push_back(apply_list_op(req));
        end
    end

    // Response side: switches between stall patterns, and on request holds
    // ready low for a long stretch.
    always @(negedge clk) begin : response_sink
        static t_rx_mode mode      = RX_STEADY;
        static int       mode_left = 0;
        static int       hold_left = 0;
        static int       phase     = 0;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        phase++;
        if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
        end else begin
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(RX_STEADY, RX_PATTERN));
                mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            case (mode)
                RX_STEADY: rsp_ready = 1'b1;
                RX_RANDOM: rsp_ready = 1'($urandom_range(0, 1));
                default:   rsp_ready = (phase % 7) > 2;
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [WORD_W-1:0] value);
        if (burst_left == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req.op        = op;
        req.position  = pos;
        req.new_value = value;
        req_valid     = 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_valid = 1'b0;
        while (expected_rsp.size() != 0) @(negedge clk);
    endtask

    // Picks a position in range for the op on the current list (1 on an empty
    // list, even for a read or remove), with an occasional fully random one.
    function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
        int n;
        n = list_words.size();
        if ($urandom_range(0, 9) == 0)
            return POS_W'($urandom_range(0, POS_MAX));
        if (op == OP_INSERT)
            return POS_W'($urandom_range(1, n + 1));
        return (n == 0) ? POS_W'(1) : POS_W'($urandom_range(1, n));
    endfunction

    task automatic test_empty_list();
        send_req(OP_CLEAR, 0, 0);
        send_req(OP_READ, 0, 0);
        send_req(OP_READ, 1, 0);
        send_req(OP_REMOVE, 1, 0);
        send_req(OP_INSERT, 2, 32'h1111_1111);
        send_req(OP_INSERT, 0, 32'h2222_2222);
        for (int c = OP_CLEAR + 1; c <= OP_MAX_CODE; c++)
            send_req(OP_W'(c), POS_MAX, '1);
    endtask

    task automatic test_positions();
        send_req(OP_INSERT, 1, 32'hFFFF_FFFF);
        send_req(OP_INSERT, 1, 32'h0000_0000);
        send_req(OP_APPEND, 0, 32'hA5A5_5A5A);
        send_req(OP_INSERT, 2, 32'h1234_5678);
        send_req(OP_INSERT, 5, 32'h8000_0001);
        send_req(OP_INSERT, 7, 32'h7FFF_FFFE);
        send_req(OP_READ, 1, 0);
        send_req(OP_READ, 5, 0);
        send_req(OP_READ, 6, 0);
        send_req(OP_READ, POS_MAX, 0);
        send_req(OP_REMOVE, 5, 0);
        send_req(OP_REMOVE, 1, 0);
        send_req(OP_REMOVE, 2, 0);
        send_req(OP_READ, 2, 0);
        send_req(OP_REMOVE, POS_MAX, 0);
    endtask

    task automatic test_full_list();
        send_req(OP_CLEAR, 0, 0);
        for (int k = 0; k < PLE_CAPACITY; k++)
            send_req(OP_APPEND, 0, $urandom);
        send_req(OP_APPEND, 0, 32'hDEAD_0001);
        send_req(OP_INSERT, 1, 32'hDEAD_0002);
        send_req(OP_INSERT, POS_W'(PLE_CAPACITY + 1), 32'hDEAD_0003);
        send_req(OP_READ, POS_W'(PLE_CAPACITY), 0);
        send_req(OP_REMOVE, POS_W'(PLE_CAPACITY), 0);
        send_req(OP_INSERT, POS_W'(PLE_CAPACITY), 32'h5555_AAAA);
        send_req(OP_CLEAR, 0, 0);
    endtask

    task automatic test_backpressure();
        logic [OP_W-1:0] op;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 12; k++) begin
            op = (k < 8) ? OP_INSERT : OP_READ;
            send_req(op, pick_position(op), $urandom);
        end
    endtask

    // Chooses at random, for each stretch of 40 requests, whether it tends to
    // grow or to shrink the list, so both the full and the empty list are hit.
    task automatic test_random_ops();
        logic [OP_W-1:0] op;
        bit              grow;
        int              roll;
        grow = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 40 == 0)
                grow = $urandom_range(0, 1);
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 35 : 20))
                op = OP_INSERT;
            else if (roll < (grow ? 60 : 30))
                op = OP_APPEND;
            else if (roll < (grow ? 78 : 55))
                op = OP_READ;
            else if (roll < 96)
                op = OP_REMOVE;
            else if (roll < 98)
                op = OP_CLEAR;
            else
                op = OP_W'($urandom_range(OP_CLEAR + 1, OP_MAX_CODE));
            send_req(op, pick_position(op), $urandom);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_list();
        test_positions();
        test_full_list();
        test_backpressure();
        test_random_ops();
        wait_idle();
        repeat (SETTLE) @(negedge clk);
        if (error_count == 0 && expected_rsp.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
